// ===== sv/lbnm_pkg.sv =====
// lbnm_pkg: shared types, constants and helpers of the letterbox coordinate mapper
// no dependencies
package lbnm_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM) + 1;  // holds MAX_DIM itself
  localparam int unsigned CRD_W   = $clog2(MAX_DIM);      // coordinates and quotients
  localparam int unsigned IDX_W   = 24;
  localparam int unsigned PAD_W   = 8;
  localparam int unsigned NCELL   = CRD_W;                // one quotient bit per cell
  localparam int unsigned CIDX_W  = 3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_SRC_W  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SRC_H  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TGT_W  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_TGT_H  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MODE   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_PADVAL = 3'd5;

  typedef enum logic [1:0] {
    CST_IDLE,
    CST_PREP,
    CST_DIV,
    CST_DONE
  } cfg_st_t;

  // per-axis divider lane
  typedef struct packed {
    logic [CRD_W-1:0] rem;
    logic [CRD_W-1:0] low;
    logic [CRD_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t ax;
    lane_t ay;
    logic  inv;
    logic  pad;
  } stage_t;

  // derived configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic [DIM_W-1:0] scl_w;
    logic [DIM_W-1:0] scl_h;
    logic [CRD_W-1:0] pad_l;
    logic [CRD_W-1:0] pad_t;
    logic [PAD_W-1:0] pad_val;
    logic             busy;
  } cfg_view_t;

  // clamp a size register to MAX_DIM
  function automatic logic [DIM_W-1:0] lim(input logic [DIM_W-1:0] v);
    lim = (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

endpackage

// ===== sv/lbnm_if.sv =====
// lbnm_in_if / lbnm_out_if: valid/ready channels of the coordinate mapper
// depends on lbnm_pkg
interface lbnm_in_if;
  logic                      valid;
  logic                      ready;
  logic [lbnm_pkg::CRD_W-1:0] out_x;
  logic [lbnm_pkg::CRD_W-1:0] out_y;
  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface lbnm_out_if;
  logic                      valid;
  logic                      ready;
  logic [lbnm_pkg::CRD_W-1:0] src_x;
  logic [lbnm_pkg::CRD_W-1:0] src_y;
  logic [lbnm_pkg::IDX_W-1:0] src_index;
  logic                      is_pad;
  logic [lbnm_pkg::PAD_W-1:0] pad_byte;
  logic                      invalid;
  modport source (output valid, output src_x, output src_y, output src_index,
                  output is_pad, output pad_byte, output invalid, input ready);
  modport sink   (input valid, input src_x, input src_y, input src_index,
                  input is_pad, input pad_byte, input invalid, output ready);
endinterface

// ===== sv/letterbox_nearest_coord_map_unit.sv =====
// letterbox_nearest_coord_map_unit: top level of the letterbox nearest-neighbor mapper
// depends on lbnm_pkg, lbnm_if, lbnm_cfg, lbnm_cell
//
// Maps one output pixel coordinate per transaction to its nearest source pixel,
// a pad flag with the pad byte, or an invalid flag. Throughput is one transaction
// per clock while out_px.ready is high and no configuration is being derived; the
// result passes through fourteen register stages (one front stage with the offset
// multipliers, twelve divider cells that each resolve one quotient bit per axis,
// and the output register with the index multiply-add). After every configuration
// write the block recomputes the scaled size and padding, in mode 1 with a
// bit-serial divider, and holds in_px.ready low until the derivation is done.
module letterbox_nearest_coord_map_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  lbnm_in_if.sink                       in_px,
  lbnm_out_if.source                    out_px,
  input  logic                          cfg_we,
  input  logic [lbnm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lbnm_pkg::DIM_W-1:0]    cfg_wdata
);

  localparam int unsigned DW = lbnm_pkg::DIM_W;
  localparam int unsigned CW = lbnm_pkg::CRD_W;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned N  = lbnm_pkg::NCELL;

  lbnm_pkg::cfg_view_t cv;

  lbnm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .view      (cv)
  );

  logic             stg_valid [0:N];
  logic             stg_rdy   [0:N+1];
  lbnm_pkg::stage_t stg_data  [0:N];

  // front stage: classify and form offset products
  logic             f_valid_r;
  lbnm_pkg::stage_t f_data_r, f_data_nxt;
  logic             accept;
  logic [CW-1:0]    offx, offy;
  logic [PW-1:0]    prx, pry;

  assign in_px.ready = stg_rdy[0] && !cv.busy;
  assign accept      = in_px.valid && in_px.ready;
  assign offx        = in_px.out_x - cv.pad_l;
  assign offy        = in_px.out_y - cv.pad_t;
  assign prx         = PW'(offx) * PW'(cv.sw);
  assign pry         = PW'(offy) * PW'(cv.sh);

  always_comb begin
    f_data_nxt.inv = (DW'(in_px.out_x) >= cv.tw) || (DW'(in_px.out_y) >= cv.th) ||
                     (cv.scl_w == '0) || (cv.scl_h == '0) ||
                     (cv.sw == '0) || (cv.sh == '0);
    f_data_nxt.pad = (in_px.out_x < cv.pad_l) || (in_px.out_y < cv.pad_t) ||
                     (DW'(offx) >= cv.scl_w) || (DW'(offy) >= cv.scl_h);
    f_data_nxt.ax.rem = prx[2*CW-1:CW];
    f_data_nxt.ax.low = prx[CW-1:0];
    f_data_nxt.ax.quo = '0;
    f_data_nxt.ay.rem = pry[2*CW-1:CW];
    f_data_nxt.ay.low = pry[CW-1:0];
    f_data_nxt.ay.quo = '0;
  end

  assign stg_rdy[0] = !f_valid_r || stg_rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (stg_rdy[0]) begin
      f_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data_r <= f_data_nxt;
    end
  end

  assign stg_valid[0] = f_valid_r;
  assign stg_data[0]  = f_data_r;

  // divider cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    lbnm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .div_x    (cv.scl_w),
      .div_y    (cv.scl_h),
      .up_valid (stg_valid[i]),
      .up_ready (stg_rdy[i+1]),
      .up_data  (stg_data[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_rdy[i+2]),
      .dn_data  (stg_data[i+1])
    );
  end

  // output register: index multiply-add and field selection
  logic                      out_valid_r, out_adv;
  logic [CW-1:0]             sx_r, sy_r;
  logic [lbnm_pkg::IDX_W-1:0] idx_r;
  logic                      pad_r, inv_r;
  logic [lbnm_pkg::PAD_W-1:0] pb_r;
  logic [PW-1:0]             idx_full;
  lbnm_pkg::stage_t          last;

  assign last     = stg_data[N];
  assign out_adv  = !out_valid_r || out_px.ready;
  assign stg_rdy[N+1] = out_adv;
  assign idx_full = PW'(last.ay.quo) * PW'(cv.sw) + PW'(last.ax.quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= stg_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && stg_valid[N]) begin
      priority if (last.inv) begin
        sx_r  <= '0;
        sy_r  <= '0;
        idx_r <= '0;
        pad_r <= 1'b0;
        pb_r  <= '0;
        inv_r <= 1'b1;
      end else if (last.pad) begin
        sx_r  <= '0;
        sy_r  <= '0;
        idx_r <= '0;
        pad_r <= 1'b1;
        pb_r  <= cv.pad_val;
        inv_r <= 1'b0;
      end else begin
        sx_r  <= last.ax.quo;
        sy_r  <= last.ay.quo;
        idx_r <= idx_full[lbnm_pkg::IDX_W-1:0];
        pad_r <= 1'b0;
        pb_r  <= '0;
        inv_r <= 1'b0;
      end
    end
  end

  assign out_px.valid     = out_valid_r;
  assign out_px.src_x     = sx_r;
  assign out_px.src_y     = sy_r;
  assign out_px.src_index = idx_r;
  assign out_px.is_pad    = pad_r;
  assign out_px.pad_byte  = pb_r;
  assign out_px.invalid   = inv_r;

endmodule

// ===== sv/lbnm_cfg.sv =====
// lbnm_cfg: configuration registers and derivation of scaled size and padding
// depends on lbnm_pkg; uses a bit-serial divider for the letterbox ratio
module lbnm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lbnm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lbnm_pkg::DIM_W-1:0]    cfg_wdata,
  output lbnm_pkg::cfg_view_t           view
);

  localparam int unsigned DW = lbnm_pkg::DIM_W;
  localparam int unsigned CW = lbnm_pkg::CRD_W;
  localparam int unsigned NW = 2 * DW;          // product width
  localparam int unsigned QW = 2 * CW + 1;      // quotient width
  localparam int unsigned KW = $clog2(QW);

  logic [DW-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic          mode_r;
  logic [lbnm_pkg::PAD_W-1:0] pad_val_r;
  logic [DW-1:0] scl_w_r, scl_w_nxt, scl_h_r, scl_h_nxt;
  logic [CW-1:0] pad_l_r, pad_l_nxt, pad_t_r, pad_t_nxt;
  lbnm_pkg::cfg_st_t st_r, st_nxt;
  logic [QW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt, den_r, den_nxt, tgt_r, tgt_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          div_w_r, div_w_nxt, use_div_r, use_div_nxt;

  logic [DW-1:0] sw, sh, tw, th, trial, qcl;
  logic [NW-1:0] p1, p2;

  assign sw = lbnm_pkg::lim(src_w_r);
  assign sh = lbnm_pkg::lim(src_h_r);
  assign tw = lbnm_pkg::lim(tgt_w_r);
  assign th = lbnm_pkg::lim(tgt_h_r);
  assign p1 = NW'(tw) * NW'(sh);
  assign p2 = NW'(th) * NW'(sw);
  assign trial = {rem_r[DW-2:0], num_r[QW-1]};
  assign qcl = (quo_r > QW'(tgt_r)) ? tgt_r : DW'(quo_r);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r   <= DW'(640);
      src_h_r   <= DW'(480);
      tgt_w_r   <= DW'(640);
      tgt_h_r   <= DW'(640);
      mode_r    <= 1'b1;
      pad_val_r <= 8'd114;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbnm_pkg::REG_SRC_W:  src_w_r   <= cfg_wdata;
        lbnm_pkg::REG_SRC_H:  src_h_r   <= cfg_wdata;
        lbnm_pkg::REG_TGT_W:  tgt_w_r   <= cfg_wdata;
        lbnm_pkg::REG_TGT_H:  tgt_h_r   <= cfg_wdata;
        lbnm_pkg::REG_MODE:   mode_r    <= cfg_wdata[0];
        lbnm_pkg::REG_PADVAL: pad_val_r <= cfg_wdata[lbnm_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // derivation sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= lbnm_pkg::CST_IDLE;
      scl_w_r <= DW'(640);
      scl_h_r <= DW'(480);
      pad_l_r <= CW'(0);
      pad_t_r <= CW'(80);
    end else begin
      st_r    <= st_nxt;
      scl_w_r <= scl_w_nxt;
      scl_h_r <= scl_h_nxt;
      pad_l_r <= pad_l_nxt;
      pad_t_r <= pad_t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    tgt_r     <= tgt_nxt;
    cnt_r     <= cnt_nxt;
    div_w_r   <= div_w_nxt;
    use_div_r <= use_div_nxt;
  end

  // next state: choose tight axis (mode 1), divide one bit a cycle, clamp and center
  always_comb begin
    logic [DW-1:0] sw_f, sh_f;
    st_nxt      = st_r;
    scl_w_nxt   = scl_w_r;
    scl_h_nxt   = scl_h_r;
    pad_l_nxt   = pad_l_r;
    pad_t_nxt   = pad_t_r;
    num_nxt     = num_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    tgt_nxt     = tgt_r;
    cnt_nxt     = cnt_r;
    div_w_nxt   = div_w_r;
    use_div_nxt = use_div_r;
    sw_f        = scl_w_r;
    sh_f        = scl_h_r;
    unique case (st_r)
      lbnm_pkg::CST_IDLE: ;
      lbnm_pkg::CST_PREP: begin
        use_div_nxt = 1'b0;
        quo_nxt     = '0;
        rem_nxt     = '0;
        cnt_nxt     = '0;
        st_nxt      = lbnm_pkg::CST_DONE;
        if (sw == '0 || sh == '0) begin
          scl_w_nxt = '0;
          scl_h_nxt = '0;
        end else if (!mode_r) begin
          scl_w_nxt = tw;
          scl_h_nxt = th;
        end else if (p1 <= p2) begin
          scl_w_nxt   = tw;
          num_nxt     = QW'(p1);
          den_nxt     = sw;
          tgt_nxt     = th;
          div_w_nxt   = 1'b0;
          use_div_nxt = 1'b1;
          st_nxt      = lbnm_pkg::CST_DIV;
        end else begin
          scl_h_nxt   = th;
          num_nxt     = QW'(p2);
          den_nxt     = sh;
          tgt_nxt     = tw;
          div_w_nxt   = 1'b1;
          use_div_nxt = 1'b1;
          st_nxt      = lbnm_pkg::CST_DIV;
        end
      end
      lbnm_pkg::CST_DIV: begin
        num_nxt = {num_r[QW-2:0], 1'b0};
        if (trial >= den_r) begin
          rem_nxt = trial - den_r;
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + KW'(1);
        if (cnt_r == KW'(QW - 1)) begin
          st_nxt = lbnm_pkg::CST_DONE;
        end
      end
      lbnm_pkg::CST_DONE: begin
        if (use_div_r) begin
          if (div_w_r) begin
            sw_f = qcl;
          end else begin
            sh_f = qcl;
          end
        end
        scl_w_nxt = sw_f;
        scl_h_nxt = sh_f;
        pad_l_nxt = CW'((tw - sw_f) >> 1);
        pad_t_nxt = CW'((th - sh_f) >> 1);
        st_nxt    = lbnm_pkg::CST_IDLE;
      end
      default: st_nxt = lbnm_pkg::CST_IDLE;
    endcase
    // any write restarts the derivation
    if (cfg_we) begin
      st_nxt = lbnm_pkg::CST_PREP;
    end
  end

  assign view.sw      = sw;
  assign view.sh      = sh;
  assign view.tw      = tw;
  assign view.th      = th;
  assign view.scl_w   = scl_w_r;
  assign view.scl_h   = scl_h_r;
  assign view.pad_l   = pad_l_r;
  assign view.pad_t   = pad_t_r;
  assign view.pad_val = pad_val_r;
  assign view.busy    = (st_r != lbnm_pkg::CST_IDLE) || cfg_we;

endmodule

// ===== sv/lbnm_cell.sv =====
// lbnm_cell: one stage of the pipelined divider, one quotient bit per axis
// depends on lbnm_pkg
module lbnm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lbnm_pkg::DIM_W-1:0]  div_x,
  input  logic [lbnm_pkg::DIM_W-1:0]  div_y,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  lbnm_pkg::stage_t            up_data,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output lbnm_pkg::stage_t            dn_data
);

  localparam int unsigned DW = lbnm_pkg::DIM_W;
  localparam int unsigned CW = lbnm_pkg::CRD_W;

  logic             valid_r;
  lbnm_pkg::stage_t data_r, data_nxt;

  // shift in next dividend bit, subtract when it fits
  function automatic lbnm_pkg::lane_t step(input lbnm_pkg::lane_t l,
                                           input logic [DW-1:0] d);
    lbnm_pkg::lane_t o;
    logic [DW-1:0]   t;
    t     = {l.rem, l.low[CW-1]};
    o.low = {l.low[CW-2:0], 1'b0};
    if (t >= d) begin
      o.rem = CW'(t - d);
      o.quo = {l.quo[CW-2:0], 1'b1};
    end else begin
      o.rem = CW'(t);
      o.quo = {l.quo[CW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    data_nxt     = up_data;
    data_nxt.ax  = step(up_data.ax, div_x);
    data_nxt.ay  = step(up_data.ay, div_y);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
